@@ design/bpc_pkg.sv @@
// Shared types, constants and tables of the barometric compensation pipeline.
// No dependencies.
`timescale 1ns / 1ps
package bpc_pkg;

   typedef logic signed [31:0] s32_type;

   // Pipeline depth: temperature 5, pressure 11, altitude 4 stages.
   localparam int NSTG     = 20;
   localparam int TEMP_STG = 5;
   localparam int PRES_STG = 11;
   localparam int ALT_STG  = 4;

   // Configuration register indexes.
   typedef enum logic [2:0] {
      REG_CALIB_A  = 3'd0,
      REG_CALIB_B  = 3'd1,
      REG_CALIB_C  = 3'd2,
      REG_VERSION3 = 3'd3,
      REG_RESIDUAL = 3'd4,
      REG_ALT_OFS  = 3'd5
   } reg_index_type;

   typedef struct packed {
      s32_type c0;
      s32_type c1;
      s32_type c2;
      s32_type c3;
      s32_type c4;
      s32_type c5;
      s32_type c6;
      s32_type c7;
      s32_type c8;
      s32_type c9;
      s32_type c10;
      s32_type c11;
      s32_type c12;
   } coef_type;

   typedef struct packed {
      logic       version_three;
      logic [1:0] residual_mode;
   } mode_type;

   // Altitude segments: base pressure (Pa), constant, linear and square terms.
   localparam int ALT_BASE [16] = '{103000, 98000, 93000, 88000, 83000, 78000, 73000,
      68000, 63000, 58000, 53000, 48000, 43000, 38000, 33000, 28000};
   localparam int ALT_C1 [16] = '{-138507, 280531, 717253, 1173421, 1651084, 2152645,
      2680954, 3239426, 3832204, 4464387, 5142359, 5874268, 6670762, 7546157, 8520395,
      9622536};
   localparam int ALT_C2 [16] = '{-21007, -21869, -22813, -23854, -25007, -26292,
      -27735, -29366, -31229, -33377, -35885, -38855, -42434, -46841, -52412, -59704};
   localparam int ALT_C3 [16] = '{311, 338, 370, 407, 450, 501, 560, 632, 719, 826,
      960, 1131, 1354, 1654, 2072, 2682};

   function automatic coef_type decode_coef(logic [62:0] a, logic [59:0] b,
                                            logic [36:0] c);
      coef_type r;
      r.c0  = 32'(signed'(a[11:0]));
      r.c1  = 32'(signed'(a[22:12]));
      r.c2  = 32'(signed'(a[31:23]));
      r.c3  = 32'(signed'(a[44:32]));
      r.c4  = 32'(signed'(a[62:45]));
      r.c5  = 32'(signed'(b[14:0]));
      r.c6  = 32'(signed'(b[27:15]));
      r.c7  = 32'(signed'(b[46:28]));
      r.c8  = 32'(signed'(b[59:47]));
      r.c9  = 32'(signed'(c[13:0]));
      r.c10 = 32'(signed'(c[23:14]));
      r.c11 = 32'(signed'(c[31:24]));
      r.c12 = 32'(signed'(c[36:32]));
      return r;
   endfunction

   // Low 11 bits as a non-negative value.
   function automatic s32_type lo11(s32_type a);
      return {21'd0, a[10:0]};
   endfunction

endpackage

@@ design/bpc_req_if.sv @@
// Input channel: one raw pressure and temperature pair per item.
// No dependencies.
`timescale 1ns / 1ps
interface bpc_req_if;
   logic        valid;
   logic        ready;
   logic [23:0] raw_pressure;
   logic [23:0] raw_temperature;

   modport source (output valid, raw_pressure, raw_temperature, input ready);
   modport sink (input valid, raw_pressure, raw_temperature, output ready);
endinterface

@@ design/bpc_rsp_if.sv @@
// Result channel: compensated temperature, pressure and altitude per item.
// No dependencies.
`timescale 1ns / 1ps
interface bpc_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] temperature_centi;
   logic [17:0]        pressure_pa;
   logic signed [24:0] altitude_mm;

   modport source (output valid, temperature_centi, pressure_pa, altitude_mm,
                   input ready);
   modport sink (input valid, temperature_centi, pressure_pa, altitude_mm,
                 output ready);
endinterface

@@ design/bpc_temp.sv @@
// Temperature polynomial stages: raw temperature to rt and dt2.
// Depends on bpc_pkg.
`timescale 1ns / 1ps
module bpc_temp (
   input  logic                      clock,
   input  logic [bpc_pkg::TEMP_STG-1:0] en,
   input  bpc_pkg::coef_type         coef,
   input  logic [23:0]               raw_pressure,
   input  logic [23:0]               raw_temperature,
   output bpc_pkg::s32_type          rt,
   output bpc_pkg::s32_type          dt2,
   output logic [23:0]               up
);
   bpc_pkg::s32_type ut32;
   bpc_pkg::s32_type dt1_ff, dt2s_ff, dt3_ff;
   bpc_pkg::s32_type x01a_ff, x01b_ff, x01c_ff, x02_ff, x02b_ff, x03_ff;
   bpc_pkg::s32_type b1_ff, g1_ff, g2_ff;
   bpc_pkg::s32_type rt_ff, dt2_ff;
   logic [23:0]      up1_ff, up2_ff, up3_ff, up4_ff, up5_ff;

   assign ut32 = signed'({8'd0, raw_temperature});

   always_ff @(posedge clock) begin
      if (en[0]) begin
         dt1_ff <= ((ut32 - 32'sd8388608) >>> 4) + (coef.c0 <<< 4);
         up1_ff <= raw_pressure;
      end
      if (en[1]) begin
         x01a_ff <= ((coef.c1 + 32'sd4459) * dt1_ff) >>> 1;
         b1_ff   <= ((coef.c2 - 32'sd256) * dt1_ff) >>> 14;
         g1_ff   <= (coef.c3 * dt1_ff) >>> 18;
         dt2s_ff <= dt1_ff;
         up2_ff  <= up1_ff;
      end
      if (en[2]) begin
         x02_ff  <= (b1_ff * dt2s_ff) >>> 4;
         g2_ff   <= (g1_ff * dt2s_ff) >>> 18;
         x01b_ff <= x01a_ff;
         dt3_ff  <= dt2s_ff;
         up3_ff  <= up2_ff;
      end
      if (en[3]) begin
         x03_ff  <= g2_ff * dt3_ff;
         x02b_ff <= x02_ff;
         x01c_ff <= x01b_ff;
         up4_ff  <= up3_ff;
      end
      if (en[4]) begin
         rt_ff  <= (32'sd81920000 - x01c_ff - x02b_ff - x03_ff) >>> 15;
         dt2_ff <= (x01c_ff + x02b_ff + x03_ff) >>> 12;
         up5_ff <= up4_ff;
      end
   end

   assign rt  = rt_ff;
   assign dt2 = dt2_ff;
   assign up  = up5_ff;
endmodule

@@ design/bpc_press.sv @@
// Pressure polynomial and residual correction stages: rt, dt2, raw pressure to Pa.
// Depends on bpc_pkg.
`timescale 1ns / 1ps
module bpc_press (
   input  logic                         clock,
   input  logic [bpc_pkg::PRES_STG-1:0] en,
   input  bpc_pkg::coef_type            coef,
   input  bpc_pkg::mode_type            mode,
   input  bpc_pkg::s32_type             rt,
   input  bpc_pkg::s32_type             dt2,
   input  logic [23:0]                  up,
   output logic [17:0]                  pressure,
   output logic signed [15:0]           temp_centi
);
   bpc_pkg::s32_type up32, k, rpc;
   logic signed [15:0] tc_in;

   // stage 6
   bpc_pkg::s32_type x11_6, m12_6, x21_6, m22_6, cf_6, drt_6, rtm1_6, rtm2_6, dpc2_6;
   bpc_pkg::s32_type rt_6, dt2_6;
   logic [23:0]      up_6;
   // stage 7
   bpc_pkg::s32_type x11_7, x12_7, x21_7, x22_7, cf10_7, cf11_7, r1_7, drt_7, dp2_7;
   logic             use2_7;
   logic [23:0]      up_7;
   // stage 8
   bpc_pkg::s32_type x23_8, pp1_8, dp1_8, dp2_8, cf10_8, cf11_8;
   logic             ge_8, use2_8;
   // stage 9
   bpc_pkg::s32_type x24_9, x25_9, pp1_9, dp1_9, dp2_9, cf10_9, cf11_9;
   logic             ge_9, use2_9;
   // stage 10
   bpc_pkg::s32_type x26_10, pp1_10, dp1_10, dp2_10, cf10_10, cf11_10;
   logic             use2_10;
   // stage 11
   bpc_pkg::s32_type pp2_11, pp3_11, dp1_11, dp2_11, cf10_11, cf11_11;
   logic             use2_11;
   // stage 12
   bpc_pkg::s32_type pp4_12, dp1_12, dp2_12, cf10_12, cf11_12;
   logic             use2_12;
   // stage 13
   bpc_pkg::s32_type x31_13, m32_13, pp4_13, dp1_13, dp2_13;
   logic             use2_13;
   // stage 14
   bpc_pkg::s32_type x31_14, x32_14, pp4_14, dp1_14, dp2_14;
   logic             use2_14;
   // stage 15
   bpc_pkg::s32_type rp_15, dp1_15, dp2_15;
   logic             use2_15;
   // stage 16
   logic [17:0]      p_16;
   // temperature rides along
   logic signed [15:0] tc_ff [6:16];

   assign up32 = signed'({8'd0, up_7});
   assign k    = coef.c7 + 32'sd166426;

   always_comb begin
      if (rt > 32'sd32767) begin
         tc_in = 16'sh7FFF;
      end else if (rt < -32'sd32768) begin
         tc_in = -16'sh8000;
      end else begin
         tc_in = rt[15:0];
      end
   end

   // Residual corrections in version-3 mode.
   always_comb begin
      rpc = rp_15;
      if (mode.version_three && mode.residual_mode[0]) begin
         rpc = rpc - dp1_15;
      end
      if (mode.version_three && mode.residual_mode[1] && use2_15) begin
         rpc = rpc - dp2_15;
      end
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         x11_6  <= (coef.c5 - 32'sd4443) * dt2;
         m12_6  <= (coef.c6 * dt2) >>> 16;
         x21_6  <= ((coef.c8 + 32'sd7180) * dt2) >>> 10;
         m22_6  <= (coef.c9 * dt2) >>> 17;
         cf_6   <= (32'sd2097152 + coef.c12 * dt2) >>> 3;
         drt_6  <= rt - 32'sd2500;
         rtm1_6 <= rt * -32'sd1513;
         rtm2_6 <= rt * 32'sd819;
         dpc2_6 <= (((32'sd549 * (coef.c5 - 32'sd16384)) >>> 9) + 32'sd559) >>> 4;
         rt_6   <= rt;
         dt2_6  <= dt2;
         up_6   <= up;
         tc_ff[6] <= tc_in;
      end
      if (en[1]) begin
         x12_7  <= (m12_6 * dt2_6) >>> 2;
         x22_7  <= (m22_6 * dt2_6) >>> 12;
         cf10_7 <= (cf_6 * coef.c10) >>> 17;
         cf11_7 <= (cf_6 * coef.c11) >>> 15;
         r1_7   <= (dpc2_6 * drt_6) >>> 15;
         dp2_7  <= ((rtm1_6 >>> 16) + 32'sd46)
                   + ((rt_6 < 32'sd700) ? ((rtm2_6 >>> 16) - 32'sd9) : 32'sd0);
         use2_7 <= rt_6 < 32'sd2000;
         x11_7  <= x11_6;
         x21_7  <= x21_6;
         drt_7  <= drt_6;
         up_7   <= up_6;
         tc_ff[7] <= tc_ff[6];
      end
      if (en[2]) begin
         pp1_8  <= (up32 - 32'sd8388608
                    - ((((x11_7 + x12_7) >>> 10)) + ((coef.c4 + 32'sd120586) <<< 4))) >>> 3;
         ge_8   <= x21_7 >= x22_7;
         x23_8  <= (x22_7 >= x21_7) ? (x22_7 - x21_7) : (x21_7 - x22_7);
         dp1_8  <= (r1_7 * drt_7) >>> 11;
         dp2_8  <= dp2_7;
         use2_8 <= use2_7;
         cf10_8 <= cf10_7;
         cf11_8 <= cf11_7;
         tc_ff[8] <= tc_ff[7];
      end
      if (en[3]) begin
         x24_9  <= (x23_8 >>> 11) * k;
         x25_9  <= (bpc_pkg::lo11(x23_8) * k) >>> 11;
         ge_9   <= ge_8;
         pp1_9  <= pp1_8;
         dp1_9  <= dp1_8;
         dp2_9  <= dp2_8;
         use2_9 <= use2_8;
         cf10_9 <= cf10_8;
         cf11_9 <= cf11_8;
         tc_ff[9] <= tc_ff[8];
      end
      if (en[4]) begin
         x26_10  <= ge_9 ? (((32'sd0 - x24_9 - x25_9) >>> 11) + k)
                         : (((x24_9 + x25_9) >>> 11) + k);
         pp1_10  <= pp1_9;
         dp1_10  <= dp1_9;
         dp2_10  <= dp2_9;
         use2_10 <= use2_9;
         cf10_10 <= cf10_9;
         cf11_10 <= cf11_9;
         tc_ff[10] <= tc_ff[9];
      end
      if (en[5]) begin
         pp2_11  <= (x26_10 >>> 11) * pp1_10;
         pp3_11  <= (bpc_pkg::lo11(x26_10) * pp1_10) >>> 11;
         dp1_11  <= dp1_10;
         dp2_11  <= dp2_10;
         use2_11 <= use2_10;
         cf10_11 <= cf10_10;
         cf11_11 <= cf11_10;
         tc_ff[11] <= tc_ff[10];
      end
      if (en[6]) begin
         pp4_12  <= (pp2_11 + pp3_11) >>> 10;
         dp1_12  <= dp1_11;
         dp2_12  <= dp2_11;
         use2_12 <= use2_11;
         cf10_12 <= cf10_11;
         cf11_12 <= cf11_11;
         tc_ff[12] <= tc_ff[11];
      end
      if (en[7]) begin
         x31_13  <= (cf10_12 * pp4_12) >>> 2;
         m32_13  <= (cf11_12 * pp4_12) >>> 18;
         pp4_13  <= pp4_12;
         dp1_13  <= dp1_12;
         dp2_13  <= dp2_12;
         use2_13 <= use2_12;
         tc_ff[13] <= tc_ff[12];
      end
      if (en[8]) begin
         x32_14  <= m32_13 * pp4_13;
         x31_14  <= x31_13;
         pp4_14  <= pp4_13;
         dp1_14  <= dp1_13;
         dp2_14  <= dp2_13;
         use2_14 <= use2_13;
         tc_ff[14] <= tc_ff[13];
      end
      if (en[9]) begin
         rp_15   <= ((x31_14 + x32_14) >>> 15) + pp4_14 + 32'sd100000;
         dp1_15  <= dp1_14;
         dp2_15  <= dp2_14;
         use2_15 <= use2_14;
         tc_ff[15] <= tc_ff[14];
      end
      if (en[10]) begin
         if (rpc < 32'sd0) begin
            p_16 <= 18'd0;
         end else if (rpc > 32'sd262143) begin
            p_16 <= 18'h3FFFF;
         end else begin
            p_16 <= rpc[17:0];
         end
         tc_ff[16] <= tc_ff[15];
      end
   end

   assign pressure   = p_16;
   assign temp_centi = tc_ff[16];
endmodule

@@ design/bpc_alt.sv @@
// Altitude stages: piecewise quadratic in pressure, offset, saturation; output registers.
// Depends on bpc_pkg.
`timescale 1ns / 1ps
module bpc_alt (
   input  logic                        clock,
   input  logic [bpc_pkg::ALT_STG-1:0] en,
   input  logic [17:0]                 pressure,
   input  logic signed [15:0]          temp_centi,
   input  logic signed [24:0]          offset_mm,
   output logic signed [15:0]          temp_out,
   output logic [17:0]                 pressure_out,
   output logic signed [24:0]          altitude_out
);
   logic [3:0]         seg;
   logic signed [18:0] dp0_17, dp0_18;
   logic signed [24:0] a1_17, a1_18, a1_19;
   logic signed [16:0] a2_17;
   logic signed [12:0] a3_17;
   logic signed [47:0] ma_18, ma_19, mc_19, alt_sum, alt_net;
   logic signed [21:0] mb_18;
   logic signed [31:0] mb_full;
   logic [17:0]        p_ff [17:20];
   logic signed [15:0] tc_ff [17:20];
   logic signed [24:0] alt_ff;

   // First segment whose base the pressure reaches; last segment otherwise.
   always_comb begin
      seg = 4'd15;
      for (int i = 14; i >= 0; i--) begin
         if (signed'({14'd0, pressure}) >= bpc_pkg::ALT_BASE[i]) begin
            seg = 4'(i);
         end
      end
   end

   assign mb_full = a3_17 * dp0_17;
   assign alt_sum = (48'(a1_19) <<< 6) + (ma_19 >>> 2) + (mc_19 >>> 4);
   assign alt_net = (alt_sum >>> 6) - 48'(offset_mm);

   always_ff @(posedge clock) begin
      if (en[0]) begin
         dp0_17 <= 19'(signed'({14'd0, pressure}) - bpc_pkg::ALT_BASE[seg]);
         a1_17  <= 25'(bpc_pkg::ALT_C1[seg]);
         a2_17  <= 17'(bpc_pkg::ALT_C2[seg]);
         a3_17  <= 13'(bpc_pkg::ALT_C3[seg]);
         p_ff[17]  <= pressure;
         tc_ff[17] <= temp_centi;
      end
      if (en[1]) begin
         ma_18  <= a2_17 * dp0_17;
         mb_18  <= 22'(mb_full >>> 10);
         dp0_18 <= dp0_17;
         a1_18  <= a1_17;
         p_ff[18]  <= p_ff[17];
         tc_ff[18] <= tc_ff[17];
      end
      if (en[2]) begin
         mc_19 <= mb_18 * dp0_18;
         ma_19 <= ma_18;
         a1_19 <= a1_18;
         p_ff[19]  <= p_ff[18];
         tc_ff[19] <= tc_ff[18];
      end
      if (en[3]) begin
         if (alt_net > 48'sd16777215) begin
            alt_ff <= 25'sh0FFFFFF;
         end else if (alt_net < -48'sd16777216) begin
            alt_ff <= -25'sh1000000;
         end else begin
            alt_ff <= alt_net[24:0];
         end
         p_ff[20]  <= p_ff[19];
         tc_ff[20] <= tc_ff[19];
      end
   end

   assign temp_out     = tc_ff[20];
   assign pressure_out = p_ff[20];
   assign altitude_out = alt_ff;
endmodule

@@ design/baro_pressure_temp_altitude_comp_unit.sv @@
// Top level of the barometric compensation pipeline: config registers and flow control.
// Depends on bpc_pkg, bpc_req_if, bpc_rsp_if, bpc_temp, bpc_press, bpc_alt.
`timescale 1ns / 1ps
// Usage
//   req_chan carries one raw pressure / raw temperature item; rsp_chan returns
//   one item of temperature (0.01 degC), pressure (Pa) and altitude (mm) for
//   each, in order. Both channels move an item when valid and ready are high.
//   csr_wr_en/csr_index/csr_data write the six config registers (calibration
//   words, version-3 enable, residual mode, altitude offset); write them only
//   while no item is in flight. Unknown indexes are dropped.
// Pipeline
//   20 register stages, the first loaded on the accepting edge; one item per
//   cycle sustained while rsp_chan.ready is high. The stages are 5 temperature,
//   11 pressure and 4 altitude, along a chain of dependent multiplies.
// Reset
//   Synchronous, active high: pipeline valid bits clear, calibration words
//   and offset go to zero, version-3 and both residual corrections enabled.
// Stall
//   Each stage holds when it is full and the stage after it cannot take its
//   item; bubbles collapse, so inputs are still taken while the output
//   register waits until every stage is occupied.
module baro_pressure_temp_altitude_comp_unit (
   input  logic             clock,
   input  logic             reset,
   bpc_req_if.sink          req_chan,
   bpc_rsp_if.source        rsp_chan,
   input  logic             csr_wr_en,
   input  logic [2:0]       csr_index,
   input  logic [62:0]      csr_data
);
   localparam int N = bpc_pkg::NSTG;

   logic [62:0]        calib_a_ff;
   logic [59:0]        calib_b_ff;
   logic [36:0]        calib_c_ff;
   logic               version3_ff;
   logic [1:0]         residual_ff;
   logic signed [24:0] alt_ofs_ff;

   bpc_pkg::coef_type  coef;
   bpc_pkg::mode_type  mode;

   logic [N-1:0] vld_ff, vld_in, en;

   bpc_pkg::s32_type   rt, dt2;
   logic [23:0]        up;
   logic [17:0]        p_mid;
   logic signed [15:0] tc_mid;

   // Config writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         calib_a_ff  <= '0;
         calib_b_ff  <= '0;
         calib_c_ff  <= '0;
         version3_ff <= 1'b1;
         residual_ff <= 2'd3;
         alt_ofs_ff  <= '0;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            bpc_pkg::REG_CALIB_A:  calib_a_ff  <= csr_data;
            bpc_pkg::REG_CALIB_B:  calib_b_ff  <= csr_data[59:0];
            bpc_pkg::REG_CALIB_C:  calib_c_ff  <= csr_data[36:0];
            bpc_pkg::REG_VERSION3: version3_ff <= csr_data[0];
            bpc_pkg::REG_RESIDUAL: residual_ff <= csr_data[1:0];
            bpc_pkg::REG_ALT_OFS:  alt_ofs_ff  <= csr_data[24:0];
            default: ;
         endcase
      end
   end

   assign coef = bpc_pkg::decode_coef(calib_a_ff, calib_b_ff, calib_c_ff);
   assign mode.version_three = version3_ff;
   assign mode.residual_mode = residual_ff;

   // A stage loads when it is empty or some later stage (or the sink) frees room.
   for (genvar k = 0; k < N; k++) begin : g_en
      assign en[k] = rsp_chan.ready || !(&vld_ff[N-1:k]);
   end

   always_comb begin
      vld_in = vld_ff;
      for (int k = 0; k < N; k++) begin
         if (en[k]) begin
            vld_in[k] = (k == 0) ? req_chan.valid : vld_ff[(k == 0) ? 0 : k - 1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   assign req_chan.ready = en[0];
   assign rsp_chan.valid = vld_ff[N-1];

   bpc_temp u_temp (
      .clock           (clock),
      .en              (en[bpc_pkg::TEMP_STG-1:0]),
      .coef            (coef),
      .raw_pressure    (req_chan.raw_pressure),
      .raw_temperature (req_chan.raw_temperature),
      .rt              (rt),
      .dt2             (dt2),
      .up              (up)
   );

   bpc_press u_press (
      .clock      (clock),
      .en         (en[bpc_pkg::TEMP_STG+bpc_pkg::PRES_STG-1:bpc_pkg::TEMP_STG]),
      .coef       (coef),
      .mode       (mode),
      .rt         (rt),
      .dt2        (dt2),
      .up         (up),
      .pressure   (p_mid),
      .temp_centi (tc_mid)
   );

   bpc_alt u_alt (
      .clock        (clock),
      .en           (en[N-1:bpc_pkg::TEMP_STG+bpc_pkg::PRES_STG]),
      .pressure     (p_mid),
      .temp_centi   (tc_mid),
      .offset_mm    (alt_ofs_ff),
      .temp_out     (rsp_chan.temperature_centi),
      .pressure_out (rsp_chan.pressure_pa),
      .altitude_out (rsp_chan.altitude_mm)
   );

   // An accepted item occupies the first stage next cycle.
   a_accept_fill: assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready) |=> vld_ff[0])
      else $error("accepted item missing from first stage");

   // Full pipeline with a stalled sink takes no new item.
   a_full_block: assert property (@(posedge clock) disable iff (reset)
      ((&vld_ff) && !rsp_chan.ready) |-> !req_chan.ready)
      else $error("input taken while pipeline full and stalled");

   // The item behind a stalled output is kept.
   a_hold_behind: assert property (@(posedge clock) disable iff (reset)
      (vld_ff[N-2] && vld_ff[N-1] && !rsp_chan.ready) |=> vld_ff[N-2])
      else $error("item lost behind stalled output");

endmodule
